// File: design/text_console_writer_assert.svh
// Assertion macros shared by the text console checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tcw_pkg.sv
// Package of the text console writer: geometry, codes and item types.
// Used by every module of the block; depends on nothing.
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_WIDTH   = 4;
  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int SCROLL_BASE = CELL_COUNT - COLUMNS;
  localparam int CELL_W      = $clog2(CELL_COUNT);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int TAB_CNT_W   = $clog2(TAB_WIDTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 3;

  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] CLEAR_ATTR   = 8'd2;
  localparam logic [7:0] ATTR_RESET   = 8'd2;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_TAB,
    OP_BACKSPACE,
    OP_READ,
    OP_SET,
    OP_CLEAR,
    OP_REJECT
  } op_e;

  typedef enum logic [2:0] {
    BK_FILL,
    BK_IDLE,
    BK_COPY,
    BK_TAB,
    BK_READ,
    BK_RESP
  } back_state_e;

  typedef enum logic [1:0] {
    FILL_INIT,
    FILL_CLEAR,
    FILL_SCROLL
  } fill_mode_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_cell;
    logic        status;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [7:0]        ch;
    logic [ROW_W-1:0]  row_idx;
    logic [COL_W-1:0]  col_idx;
    logic [CELL_W-1:0] addr;
  } q_entry_t;

endpackage

// File: design/tcw_front.sv
// Front end of the text console writer: accepts items and decodes them.
// Classifies each command into an operation and checks coordinates; uses tcw_pkg.
module tcw_front import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     hold_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output q_entry_t q_entry_o
);

  logic     valid_q, valid_d;
  q_entry_t entry_q, entry_d;
  q_entry_t cls;
  logic     coords_ok;
  logic [4:0] row_m1;
  logic [6:0] col_m1;

  always_comb begin
    coords_ok = (in_item_i.row != 5'd0) && (in_item_i.row <= ROWS) &&
                (in_item_i.column != 7'd0) && (in_item_i.column <= COLUMNS);
    row_m1 = in_item_i.row - 5'd1;
    col_m1 = in_item_i.column - 7'd1;
    cls.ch      = in_item_i.char_code;
    cls.row_idx = ROW_W'(row_m1);
    cls.col_idx = COL_W'(col_m1);
    cls.addr    = CELL_W'(CELL_W'(cls.row_idx) * CELL_W'(COLUMNS) + CELL_W'(cls.col_idx));
    case (cmd_e'(in_item_i.command))
      CMD_PUT: begin
        case (in_item_i.char_code)
          CH_NEWLINE:   cls.op = OP_NEWLINE;
          CH_TAB:       cls.op = OP_TAB;
          CH_BACKSPACE: cls.op = OP_BACKSPACE;
          default:      cls.op = OP_CHAR;
        endcase
      end
      CMD_READ: cls.op = coords_ok ? OP_READ : OP_REJECT;
      CMD_SET:  cls.op = coords_ok ? OP_SET : OP_REJECT;
      default:  cls.op = OP_CLEAR;
    endcase
  end

  assign in_ready_o = !hold_i && (!valid_q || q_ready_i);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      entry_d = cls;
    end else if (q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_valid_o = valid_q;
  assign q_entry_o = entry_q;

endmodule

// File: design/tcw_fifo.sv
// Short queue of decoded operations between the front and back ends.
// Holds QUEUE_DEPTH entries of q_entry_t from tcw_pkg.
module tcw_fifo import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  q_entry_t wr_entry_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output q_entry_t rd_entry_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_entry_o = slots_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// File: design/tcw_back.sv
// Back end of the text console writer: screen store, cursor and sequencer.
// Carries out decoded operations, including scroll and fill sweeps; uses tcw_pkg.
module tcw_back import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  q_entry_t  q_entry_i,
  input  logic [7:0] attr_i,
  output logic      init_busy_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [15:0]       mem_q [CELL_COUNT];
  logic [15:0]       rdata_q;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  back_state_e          state_q, state_d;
  fill_mode_e           fill_mode_q, fill_mode_d;
  logic [7:0]           fill_attr_q, fill_attr_d;
  logic [CELL_W-1:0]    cnt_q, cnt_d;
  logic [CELL_W-1:0]    cursor_q, cursor_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [TAB_CNT_W-1:0] tab_left_q, tab_left_d;
  logic [7:0]           res_char_q, res_char_d, res_attr_q, res_attr_d;
  logic                 res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic              adv_scroll;
  logic [CELL_W-1:0] adv_cursor;
  logic [ROW_W-1:0]  adv_row;
  logic [COL_W-1:0]  adv_col;
  logic [CELL_W-1:0] bs_cursor;
  logic [ROW_W-1:0]  bs_row;
  logic [COL_W-1:0]  bs_col;

  always_comb begin
    adv_scroll = 1'b0;
    adv_cursor = cursor_q + CELL_W'(1);
    adv_row    = row_q;
    adv_col    = col_q + COL_W'(1);
    if (cursor_q == CELL_W'(CELL_COUNT - 1)) begin
      adv_scroll = 1'b1;
      adv_cursor = CELL_W'(SCROLL_BASE);
      adv_row    = ROW_W'(ROWS - 1);
      adv_col    = '0;
    end else if (col_q == COL_W'(COLUMNS - 1)) begin
      adv_row = row_q + ROW_W'(1);
      adv_col = '0;
    end
    bs_cursor = cursor_q;
    bs_row    = row_q;
    bs_col    = col_q;
    if (cursor_q != '0) begin
      bs_cursor = cursor_q - CELL_W'(1);
      if (col_q == '0) begin
        bs_col = COL_W'(COLUMNS - 1);
        bs_row = row_q - ROW_W'(1);
      end else begin
        bs_col = col_q - COL_W'(1);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_mode_d  = fill_mode_q;
    fill_attr_d  = fill_attr_q;
    cnt_d        = cnt_q;
    cursor_d     = cursor_q;
    row_d        = row_q;
    col_d        = col_q;
    tab_left_d   = tab_left_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    q_ready_o    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q;
    mem_wdata    = {fill_attr_q, BLANK_CHAR};
    mem_raddr    = cnt_q;

    case (state_q)
      BK_FILL: begin
        mem_we = 1'b1;
        if (cnt_q == CELL_W'(CELL_COUNT - 1)) begin
          cnt_d = '0;
          case (fill_mode_q)
            FILL_CLEAR:  state_d = BK_RESP;
            FILL_SCROLL: state_d = BK_TAB;
            default:     state_d = BK_IDLE;
          endcase
        end else begin
          cnt_d = cnt_q + CELL_W'(1);
        end
      end
      BK_COPY: begin
        // Each cell takes the one a row below; the read data is registered and written in the next cycle.
        mem_raddr = CELL_W'(cnt_q + CELL_W'(COLUMNS));
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q - CELL_W'(1);
          mem_wdata = rdata_q;
        end
        if (cnt_q == CELL_W'(SCROLL_BASE)) begin
          state_d     = BK_FILL;
          fill_mode_d = FILL_SCROLL;
          fill_attr_d = attr_i;
        end else begin
          cnt_d = cnt_q + CELL_W'(1);
        end
      end
      BK_TAB: begin
        if (tab_left_q == '0) begin
          state_d = BK_RESP;
        end else begin
          tab_left_d = tab_left_q - TAB_CNT_W'(1);
          cursor_d   = adv_cursor;
          row_d      = adv_row;
          col_d      = adv_col;
          if (adv_scroll) begin
            state_d = BK_COPY;
            cnt_d   = '0;
          end
        end
      end
      BK_READ: begin
        res_char_d = rdata_q[7:0];
        res_attr_d = rdata_q[15:8];
        state_d    = BK_RESP;
      end
      BK_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.cell_char   = res_char_q;
          out_d.cell_attr   = res_attr_q;
          out_d.cursor_cell = 11'(cursor_q);
          out_d.status      = res_status_q;
          state_d           = BK_IDLE;
        end
      end
      BK_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          res_char_d   = '0;
          res_attr_d   = '0;
          res_status_d = 1'b0;
          state_d      = BK_RESP;
          case (q_entry_i.op)
            OP_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = cursor_q;
              mem_wdata = {attr_i, q_entry_i.ch};
              cursor_d  = adv_cursor;
              row_d     = adv_row;
              col_d     = adv_col;
              if (adv_scroll) begin
                state_d = BK_COPY;
                cnt_d   = '0;
              end
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (row_q == ROW_W'(ROWS - 1)) begin
                cursor_d = CELL_W'(SCROLL_BASE);
                state_d  = BK_COPY;
                cnt_d    = '0;
              end else begin
                cursor_d = cursor_q + CELL_W'(COLUMNS) - CELL_W'(col_q);
                row_d    = row_q + ROW_W'(1);
              end
            end
            OP_TAB: begin
              tab_left_d = TAB_CNT_W'(TAB_WIDTH);
              state_d    = BK_TAB;
            end
            OP_BACKSPACE: begin
              mem_we    = 1'b1;
              mem_waddr = bs_cursor;
              mem_wdata = {attr_i, BLANK_CHAR};
              cursor_d  = bs_cursor;
              row_d     = bs_row;
              col_d     = bs_col;
            end
            OP_READ: begin
              mem_raddr = q_entry_i.addr;
              state_d   = BK_READ;
            end
            OP_SET: begin
              cursor_d = q_entry_i.addr;
              row_d    = q_entry_i.row_idx;
              col_d    = q_entry_i.col_idx;
            end
            OP_CLEAR: begin
              state_d     = BK_FILL;
              fill_mode_d = FILL_CLEAR;
              fill_attr_d = CLEAR_ATTR;
              cnt_d       = '0;
              cursor_d    = '0;
              row_d       = '0;
              col_d       = '0;
            end
            default: begin
              res_status_d = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FILL;
      fill_mode_q <= FILL_INIT;
      fill_attr_q <= CLEAR_ATTR;
      cnt_q       <= '0;
      cursor_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      tab_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_mode_q <= fill_mode_d;
      fill_attr_q <= fill_attr_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      row_q       <= row_d;
      col_q       <= col_d;
      tab_left_q  <= tab_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign init_busy_o = (state_q == BK_FILL) && (fill_mode_q == FILL_INIT);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: design/text_console_writer.sv
// Top level of the text console writer: register port and the three parts.
// Instantiates tcw_front, tcw_fifo and tcw_back; uses tcw_pkg.
//
// Command items enter on the in channel (in_valid_i, in_ready_o, in_item_i)
// and each one gives exactly one result item on the out channel
// (out_valid_o, out_ready_i, out_item_o), in order. The text attribute is
// written over the APB port at address 0; the user must write it only while
// the block is idle, which the block does not enforce. A decode register and
// a two-entry queue sit in front of the screen sequencer, so items are taken
// while the sequencer is busy or a result waits. Each item passes the decode
// register, the queue and the sequencer, whose response state loads the
// output register, and the sequencer takes the next item only after that.
// A scroll walks the screen store one cell a cycle, copying rows up and then
// blanking the bottom row; a clear screen blanks every cell. After reset the
// store is blanked by a pass over every cell, during which in_ready_o is low;
// register writes are taken throughout. When the receiver stalls, the result
// is held in the output register and further items queue up until the queue
// is full, then in_ready_o drops.
module text_console_writer import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] attr_q;
  logic       init_busy;
  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  q_entry_t   fq_entry, bq_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1] == REG_TEXT_ATTR)) begin
      attr_q <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (init_busy),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_entry_o  (fq_entry)
  );

  tcw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_entry_i (fq_entry),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_entry_o (bq_entry)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_entry_i   (bq_entry),
    .attr_i      (attr_q),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: design/tcw_checker.sv
// Port-level checker of the text console writer, bound to the top level.
// Uses tcw_pkg and the macros of text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"

module tcw_checker import tcw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `TCW_ASSERT_IMP(a_cursor_range, out_valid_o, out_item_o.cursor_cell < 11'(CELL_COUNT), "cursor outside the screen")
  `TCW_ASSERT_IMP(a_reject_zero, out_valid_o && out_item_o.status, out_item_o.cell_char == 8'd0 && out_item_o.cell_attr == 8'd0, "rejected item carries cell bytes")
  `TCW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "stalled result item changed")

endmodule

bind text_console_writer tcw_checker u_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the text console writer: a directed table, then random
// command items in phases with different text attributes, checked with the table or
// a behavioural screen model kept here. Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 100ps

module testbench import tcw_pkg::*; ();

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 10;
  localparam int          RANDOM_ITEMS  = 700;
  localparam int          PHASES        = 6;
  localparam int          MAX_GAP       = 60;
  localparam int          DRAIN_CYCLES  = 50;
  localparam int          DIRECTED_ROWS = 25;
  localparam int unsigned CYCLE_LIMIT   =
    4 * ((RANDOM_ITEMS + DIRECTED_ROWS) * (CELL_COUNT + 2 * MAX_GAP + 40) + CELL_COUNT + 1000);
  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * REG_TEXT_ATTR);

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  in_item_t           in_item    = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  out_item_t          out_item;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [15:0]        screen_img [CELL_COUNT];
  int unsigned        cursor_pos;
  logic [7:0]         attr_reg;
  out_item_t          console_replies [$];
  int unsigned        fail_count  = 0;
  int unsigned        cycle_count = 0;
  int unsigned        stall_left  = 0;
  bit                 steady      = 1'b0;

  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{'{CMD_READ,  8'd0,         5'd1,  7'd1},   1'b1, '{BLANK_CHAR, CLEAR_ATTR, 11'd0, 1'b0}},
    '{'{CMD_READ,  8'd255,       5'd25, 7'd80},  1'b1, '{BLANK_CHAR, CLEAR_ATTR, 11'd0, 1'b0}},
    '{'{CMD_READ,  8'd0,         5'd0,  7'd1},   1'b1, '{8'd0, 8'd0, 11'd0, 1'b1}},
    '{'{CMD_READ,  8'd0,         5'd1,  7'd0},   1'b1, '{8'd0, 8'd0, 11'd0, 1'b1}},
    '{'{CMD_READ,  8'd170,       5'd31, 7'd127}, 1'b1, '{8'd0, 8'd0, 11'd0, 1'b1}},
    '{'{CMD_SET,   8'd0,         5'd26, 7'd1},   1'b1, '{8'd0, 8'd0, 11'd0, 1'b1}},
    '{'{CMD_SET,   8'd0,         5'd1,  7'd81},  1'b1, '{8'd0, 8'd0, 11'd0, 1'b1}},
    '{'{CMD_SET,   8'd0,         5'd25, 7'd80},  1'b1, '{8'd0, 8'd0, 11'(CELL_COUNT - 1), 1'b0}},
    '{'{CMD_PUT,   8'd65,        5'd0,  7'd0},   1'b1, '{8'd0, 8'd0, 11'(SCROLL_BASE), 1'b0}},
    '{'{CMD_READ,  8'd0,         5'd24, 7'd80},  1'b0, '0},
    '{'{CMD_READ,  8'd0,         5'd25, 7'd1},   1'b0, '0},
    '{'{CMD_PUT,   CH_BACKSPACE, 5'd0,  7'd0},   1'b1, '{8'd0, 8'd0, 11'(SCROLL_BASE - 1), 1'b0}},
    '{'{CMD_SET,   8'd0,         5'd1,  7'd1},   1'b1, '{8'd0, 8'd0, 11'd0, 1'b0}},
    '{'{CMD_PUT,   CH_BACKSPACE, 5'd31, 7'd127}, 1'b1, '{8'd0, 8'd0, 11'd0, 1'b0}},
    '{'{CMD_PUT,   8'd255,       5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_PUT,   8'd0,         5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_PUT,   CH_TAB,       5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_PUT,   CH_NEWLINE,   5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_SET,   8'd0,         5'd25, 7'd79},  1'b1, '{8'd0, 8'd0, 11'(CELL_COUNT - 2), 1'b0}},
    '{'{CMD_PUT,   CH_TAB,       5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_PUT,   CH_NEWLINE,   5'd0,  7'd0},   1'b0, '0},
    '{'{CMD_READ,  8'd0,         5'd1,  7'd1},   1'b0, '0},
    '{'{CMD_READ,  8'd0,         5'd23, 7'd80},  1'b0, '0},
    '{'{CMD_CLEAR, 8'd255,       5'd31, 7'd127}, 1'b1, '{8'd0, 8'd0, 11'd0, 1'b0}},
    '{'{CMD_READ,  8'd0,         5'd1,  7'd1},   1'b1, '{BLANK_CHAR, CLEAR_ATTR, 11'd0, 1'b0}}
  };

  text_console_writer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void shift_rows_up();
    for (int i = 0; i < SCROLL_BASE; i++) screen_img[i] = screen_img[i + COLUMNS];
    for (int i = SCROLL_BASE; i < CELL_COUNT; i++) screen_img[i] = {attr_reg, BLANK_CHAR};
  endfunction

  function automatic void step_right();
    if (cursor_pos + 1 >= CELL_COUNT) begin
      shift_rows_up();
      cursor_pos = SCROLL_BASE;
    end else begin
      cursor_pos++;
    end
  endfunction

  function automatic bit coords_valid(logic [4:0] r, logic [6:0] c);
    return r >= 1 && r <= ROWS && c >= 1 && c <= COLUMNS;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_img[i] = {CLEAR_ATTR, BLANK_CHAR};
    cursor_pos = 0;
  endfunction

  // Applies one command item to the screen model and returns the reply it gives.
  function automatic out_item_t console_reply(in_item_t it);
    out_item_t   rep;
    int unsigned idx;
    int unsigned next_row;
    rep = '0;
    idx = (int'(it.row) - 1) * COLUMNS + int'(it.column) - 1;
    case (cmd_e'(it.command))
      CMD_PUT: begin
        case (it.char_code)
          CH_NEWLINE: begin
            next_row = cursor_pos / COLUMNS + 1;
            if (next_row >= ROWS) begin
              shift_rows_up();
              cursor_pos = SCROLL_BASE;
            end else begin
              cursor_pos = next_row * COLUMNS;
            end
          end
          CH_TAB: begin
            repeat (TAB_WIDTH) step_right();
          end
          CH_BACKSPACE: begin
            if (cursor_pos > 0) cursor_pos--;
            screen_img[cursor_pos] = {attr_reg, BLANK_CHAR};
          end
          default: begin
            screen_img[cursor_pos] = {attr_reg, it.char_code};
            step_right();
          end
        endcase
      end
      CMD_READ: begin
        if (coords_valid(it.row, it.column)) begin
          rep.cell_char = screen_img[idx][7:0];
          rep.cell_attr = screen_img[idx][15:8];
        end else begin
          rep.status = 1'b1;
        end
      end
      CMD_SET: begin
        if (coords_valid(it.row, it.column)) cursor_pos = idx;
        else rep.status = 1'b1;
      end
      default: begin
        blank_screen();
      end
    endcase
    rep.cursor_cell = 11'(cursor_pos);
    return rep;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned pick;
    int unsigned sel;
    int unsigned spot;
    it.char_code = 8'($urandom_range(0, 255));
    it.row       = 5'($urandom_range(0, 31));
    it.column    = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.command = CMD_PUT;
      sel = $urandom_range(0, 99);
      if (sel < 8) it.char_code = CH_NEWLINE;
      else if (sel < 14) it.char_code = CH_TAB;
      else if (sel < 22) it.char_code = CH_BACKSPACE;
    end else if (pick < 93) begin
      it.command = (pick < 75) ? CMD_READ : CMD_SET;
      sel = $urandom_range(0, 9);
      if (sel >= 1) begin
        if (sel < 4 && it.command == CMD_READ && cursor_pos > 0) begin
          spot      = cursor_pos - 1;
          it.row    = 5'(spot / COLUMNS + 1);
          it.column = 7'(spot % COLUMNS + 1);
        end else if (sel < 5) begin
          it.row    = 5'(ROWS);
          it.column = 7'($urandom_range(1, COLUMNS));
        end else begin
          it.row    = 5'($urandom_range(1, ROWS));
          it.column = 7'($urandom_range(1, COLUMNS));
        end
      end
    end else begin
      it.command = CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
    int unsigned gap;
    out_item_t   rep;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rep = console_reply(it);
    console_replies.push_back(typed ? want : rep);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    attr_reg = value;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (console_replies.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %p", $time, out_item);
        fail_count++;
      end else begin
        want = console_replies.pop_front();
        check_field("cell_char", want.cell_char, out_item.cell_char);
        check_field("cell_attr", want.cell_attr, out_item.cell_attr);
        check_field("cursor_cell", want.cursor_cell, out_item.cursor_cell);
        check_field("status", want.status, out_item.status);
      end
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL text_console_writer");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_attr;
    attr_reg = ATTR_RESET;
    blank_screen();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      offer_item(directed_table[n].stim, directed_table[n].typed, directed_table[n].want);
    end
    drain_replies();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_attr = 8'd255;
        1:       phase_attr = 8'd0;
        default: phase_attr = 8'($urandom_range(0, 255));
      endcase
      write_attr(phase_attr);
      steady = (p == 3);
      for (int n = 0; n < RANDOM_ITEMS / PHASES + 1; n++) begin
        offer_item(random_command(), 1'b0, '0);
      end
      drain_replies();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule

// File: text_console_writer.f
+incdir+design
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_fifo.sv
design/tcw_back.sv
design/text_console_writer.sv
design/tcw_checker.sv
test/testbench.sv
